// File: hw/rtl/mrr_pkg.sv
package mrr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned CFG_DW   = 16;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FUNC  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CRC   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 3'd5;

    localparam logic [CFG_AW-1:0] REG_SLAVE_ADDRESS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FUNCTION_CODE = 2'd1;
    localparam logic [CFG_AW-1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [BYTE_W-1:0]  RST_SLAVE_ADDRESS = 8'h01;
    localparam logic [BYTE_W-1:0]  RST_FUNCTION_CODE = 8'h03;
    localparam logic [TICK_W-1:0]  RST_TIMEOUT_TICKS = 16'd500;
    localparam logic [BYTE_W-1:0]  EXPECT_COUNT      = 8'h02;
    localparam logic [VALUE_W-1:0] CRC_INIT          = 16'hFFFF;
    localparam logic [VALUE_W-1:0] CRC_POLY          = 16'hA001;

    typedef enum logic [2:0] {
        PH_ADDR   = 3'd0,
        PH_FUNC   = 3'd1,
        PH_COUNT  = 3'd2,
        PH_VAL_HI = 3'd3,
        PH_VAL_LO = 3'd4,
        PH_CRC_LO = 3'd5,
        PH_CRC_HI = 3'd6
    } phase_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  reading;
    } out_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] slave_address;
        logic [BYTE_W-1:0] function_code;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

endpackage

// File: hw/rtl/mrr_crc.sv
module mrr_crc (
    input  logic [mrr_pkg::VALUE_W-1:0] crc,
    input  logic [mrr_pkg::BYTE_W-1:0]  data,
    output logic [mrr_pkg::VALUE_W-1:0] crc_next
);

    always_comb
    begin
        logic [mrr_pkg::VALUE_W-1:0] c;
        c = crc ^ {{(mrr_pkg::VALUE_W - mrr_pkg::BYTE_W){1'b0}}, data};
        for (int i = 0; i < mrr_pkg::BYTE_W; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ mrr_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_next = c;
    end

endmodule

// File: hw/rtl/mrr_frame.sv
module mrr_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  logic                fire,
    input  mrr_pkg::in_word_t   word,
    input  mrr_pkg::cfg_t       cfg,
    output logic                res_valid,
    output mrr_pkg::out_word_t  res
);

    logic                          armed_reg,  armed_next;
    mrr_pkg::phase_t               phase_reg,  phase_next;
    logic [mrr_pkg::VALUE_W-1:0]   crc_reg,    crc_next;
    logic [mrr_pkg::VALUE_W-1:0]   value_reg,  value_next;
    logic [mrr_pkg::BYTE_W-1:0]    crc_lo_reg, crc_lo_next;
    logic [mrr_pkg::TICK_W-1:0]    tick_reg,   tick_next;
    logic [mrr_pkg::VALUE_W-1:0]   crc_fed;
    logic                          crc_match;

    mrr_crc u_crc (
        .crc      (crc_reg),
        .data     (word.rx_byte),
        .crc_next (crc_fed)
    );

    assign crc_match = (crc_lo_reg == crc_reg[7:0]) && (word.rx_byte == crc_reg[15:8]);

    // next state
    always_comb
    begin
        armed_next  = armed_reg;
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        value_next  = value_reg;
        crc_lo_next = crc_lo_reg;
        tick_next   = tick_reg;
        if (fire)
        begin
            if (word.mode == mrr_pkg::MODE_START)
            begin
                armed_next  = 1'b1;
                phase_next  = mrr_pkg::PH_ADDR;
                crc_next    = mrr_pkg::CRC_INIT;
                value_next  = '0;
                crc_lo_next = '0;
                tick_next   = '0;
            end
            else if (armed_reg && word.mode == mrr_pkg::MODE_TICK)
            begin
                if (tick_reg >= cfg.timeout_ticks)
                begin
                    armed_next = 1'b0;
                end
                else
                begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            else if (armed_reg && word.mode == mrr_pkg::MODE_BYTE)
            begin
                unique case (phase_reg)
                    mrr_pkg::PH_ADDR:
                    begin
                        if (word.rx_byte != cfg.slave_address)
                        begin
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            crc_next   = crc_fed;
                            tick_next  = '0;
                            phase_next = mrr_pkg::PH_FUNC;
                        end
                    end
                    mrr_pkg::PH_FUNC:
                    begin
                        if (word.rx_byte != cfg.function_code)
                        begin
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            crc_next   = crc_fed;
                            tick_next  = '0;
                            phase_next = mrr_pkg::PH_COUNT;
                        end
                    end
                    mrr_pkg::PH_COUNT:
                    begin
                        if (word.rx_byte != mrr_pkg::EXPECT_COUNT)
                        begin
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            crc_next   = crc_fed;
                            tick_next  = '0;
                            phase_next = mrr_pkg::PH_VAL_HI;
                        end
                    end
                    mrr_pkg::PH_VAL_HI:
                    begin
                        value_next = {word.rx_byte, {mrr_pkg::BYTE_W{1'b0}}};
                        crc_next   = crc_fed;
                        phase_next = mrr_pkg::PH_VAL_LO;
                    end
                    mrr_pkg::PH_VAL_LO:
                    begin
                        value_next = {value_reg[15:8], word.rx_byte};
                        crc_next   = crc_fed;
                        phase_next = mrr_pkg::PH_CRC_LO;
                    end
                    mrr_pkg::PH_CRC_LO:
                    begin
                        crc_lo_next = word.rx_byte;
                        phase_next  = mrr_pkg::PH_CRC_HI;
                    end
                    default:
                    begin
                        armed_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // result of the held word, independent of whether it fires
    always_comb
    begin
        res_valid   = 1'b0;
        res.status  = mrr_pkg::ST_OK;
        res.reading = '0;
        if (valid && armed_reg && word.mode == mrr_pkg::MODE_TICK)
        begin
            if (tick_reg >= cfg.timeout_ticks)
            begin
                res_valid  = 1'b1;
                res.status = mrr_pkg::ST_TIMEOUT;
            end
        end
        else if (valid && armed_reg && word.mode == mrr_pkg::MODE_BYTE)
        begin
            unique case (phase_reg)
                mrr_pkg::PH_ADDR:
                begin
                    res_valid  = (word.rx_byte != cfg.slave_address);
                    res.status = mrr_pkg::ST_BAD_ADDR;
                end
                mrr_pkg::PH_FUNC:
                begin
                    res_valid  = (word.rx_byte != cfg.function_code);
                    res.status = mrr_pkg::ST_BAD_FUNC;
                end
                mrr_pkg::PH_COUNT:
                begin
                    res_valid  = (word.rx_byte != mrr_pkg::EXPECT_COUNT);
                    res.status = mrr_pkg::ST_BAD_COUNT;
                end
                mrr_pkg::PH_VAL_HI, mrr_pkg::PH_VAL_LO, mrr_pkg::PH_CRC_LO:
                begin
                    res_valid = 1'b0;
                end
                default:
                begin
                    res_valid = 1'b1;
                    if (crc_match)
                    begin
                        res.status  = mrr_pkg::ST_OK;
                        res.reading = value_reg;
                    end
                    else
                    begin
                        res.status = mrr_pkg::ST_BAD_CRC;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            phase_reg  <= mrr_pkg::PH_ADDR;
            crc_reg    <= mrr_pkg::CRC_INIT;
            value_reg  <= '0;
            crc_lo_reg <= '0;
            tick_reg   <= '0;
        end
        else
        begin
            armed_reg  <= armed_next;
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            value_reg  <= value_next;
            crc_lo_reg <= crc_lo_next;
            tick_reg   <= tick_next;
        end
    end

`ifndef SYNTH
    a_res_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> armed_reg && valid)
        else $error("result while not armed");

    a_res_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && fire |=> !armed_reg)
        else $error("still armed after result");

    a_start_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && word.mode == mrr_pkg::MODE_START |=>
            armed_reg && phase_reg == mrr_pkg::PH_ADDR && tick_reg == '0
            && crc_reg == mrr_pkg::CRC_INIT)
        else $error("start did not restart reception");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != mrr_pkg::ST_OK |-> res.reading == '0)
        else $error("error result carries a reading");
`endif

endmodule

// File: hw/rtl/modbus_register_reply_receiver_top.sv
// Modbus RTU single-register read reply receiver.
// Input channel (in_valid/in_ready/in_data): one word per event; mode selects
// a received byte, a time tick or a start that arms the receiver.
// Output channel (out_valid/out_ready/out_data): one word per finished reply:
// ok with the register value, a header error, a CRC error or a timeout.
// Config port (cfg_we/cfg_addr/cfg_wdata): 0 slave address, 1 function code,
// 2 timeout in ticks; write only while no reply is in progress.
// Path: an input word is registered, decoded from the input register, and its
// result is registered onto out_data when the word is taken from there.
// Throughput: one input word per cycle while no result waits on a stalled
// output; the CRC is updated a whole byte at a time in the decode cycle.
// Reset: receiver disarmed, registers at 1 / 3 / 500, both channels empty.
// When out_ready is low the pending result holds; input words that produce
// no result keep flowing, and the next one that would produce a result waits
// in the input register, which then deasserts in_ready.
module modbus_register_reply_receiver_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  mrr_pkg::in_word_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mrr_pkg::out_word_t           out_data,
    input  logic                         cfg_we,
    input  logic [mrr_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [mrr_pkg::CFG_DW-1:0]   cfg_wdata
);

    logic                in_vld_reg;
    mrr_pkg::in_word_t   in_word_reg;
    logic                out_vld_reg;
    mrr_pkg::out_word_t  out_word_reg;
    mrr_pkg::cfg_t       cfg_reg;
    logic                fire;
    logic                res_valid;
    mrr_pkg::out_word_t  res;

    assign fire     = in_vld_reg && (!res_valid || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || fire;

    mrr_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_vld_reg),
        .fire      (fire),
        .word      (in_word_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address <= mrr_pkg::RST_SLAVE_ADDRESS;
            cfg_reg.function_code <= mrr_pkg::RST_FUNCTION_CODE;
            cfg_reg.timeout_ticks <= mrr_pkg::RST_TIMEOUT_TICKS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                mrr_pkg::REG_SLAVE_ADDRESS:
                    cfg_reg.slave_address <= cfg_wdata[mrr_pkg::BYTE_W-1:0];
                mrr_pkg::REG_FUNCTION_CODE:
                    cfg_reg.function_code <= cfg_wdata[mrr_pkg::BYTE_W-1:0];
                mrr_pkg::REG_TIMEOUT_TICKS:
                    cfg_reg.timeout_ticks <= cfg_wdata[mrr_pkg::TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_word_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire && res_valid)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_word_reg <= res;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_word_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |-> !(fire && res_valid))
        else $error("pending result overwritten");

    a_held_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !fire |=> in_vld_reg && $stable(in_word_reg))
        else $error("held input word lost");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid |=> out_vld_reg && out_word_reg == $past(res))
        else $error("result not captured");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0]                 MODE_UNUSED = 2'd3;
    localparam logic [mrr_pkg::CFG_AW-1:0] REG_UNUSED  = 2'd3;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned LIMIT       = 400000;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    mrr_pkg::in_word_t              in_data;
    logic                           out_valid;
    logic                           out_ready;
    mrr_pkg::out_word_t             out_data;
    logic                           cfg_we;
    logic [mrr_pkg::CFG_AW-1:0]     cfg_addr;
    logic [mrr_pkg::CFG_DW-1:0]     cfg_wdata;

    // receiver model state
    mrr_pkg::cfg_t                  cfg_shadow;
    logic                           rx_armed;
    mrr_pkg::phase_t                rx_phase;
    logic [mrr_pkg::VALUE_W-1:0]    crc_run;
    logic [mrr_pkg::VALUE_W-1:0]    value_acc;
    logic [mrr_pkg::BYTE_W-1:0]     crc_lo_seen;
    logic [mrr_pkg::TICK_W-1:0]     tick_run;

    mrr_pkg::out_word_t             pending_results[$];
    int unsigned                    sent_words;
    int unsigned                    errors;
    int unsigned                    cycles;
    int unsigned                    burst_left;
    bit                             gaps_on;
    bit                             hold_req;

    modbus_register_reply_receiver_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [mrr_pkg::VALUE_W-1:0] crc_byte(
        input logic [mrr_pkg::VALUE_W-1:0] c,
        input logic [mrr_pkg::BYTE_W-1:0]  b);
        logic [mrr_pkg::VALUE_W-1:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ mrr_pkg::CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    task automatic predict_word(input mrr_pkg::in_word_t w);
        mrr_pkg::out_word_t r;
        bit                 done;
        r    = '0;
        done = 1'b0;
        if (w.mode == mrr_pkg::MODE_START)
        begin
            rx_armed    = 1'b1;
            rx_phase    = mrr_pkg::PH_ADDR;
            crc_run     = mrr_pkg::CRC_INIT;
            value_acc   = '0;
            crc_lo_seen = '0;
            tick_run    = '0;
        end
        else if (rx_armed && w.mode != MODE_UNUSED)
        begin
            if (w.mode == mrr_pkg::MODE_TICK)
            begin
                if (tick_run >= cfg_shadow.timeout_ticks)
                begin
                    r.status = mrr_pkg::ST_TIMEOUT;
                    done     = 1'b1;
                end
                else
                begin
                    tick_run = tick_run + 1'b1;
                end
            end
            else
            begin
                case (rx_phase)
                    mrr_pkg::PH_ADDR:
                    begin
                        if (w.rx_byte != cfg_shadow.slave_address)
                        begin
                            r.status = mrr_pkg::ST_BAD_ADDR;
                            done     = 1'b1;
                        end
                    end
                    mrr_pkg::PH_FUNC:
                    begin
                        if (w.rx_byte != cfg_shadow.function_code)
                        begin
                            r.status = mrr_pkg::ST_BAD_FUNC;
                            done     = 1'b1;
                        end
                    end
                    mrr_pkg::PH_COUNT:
                    begin
                        if (w.rx_byte != mrr_pkg::EXPECT_COUNT)
                        begin
                            r.status = mrr_pkg::ST_BAD_COUNT;
                            done     = 1'b1;
                        end
                    end
                    mrr_pkg::PH_VAL_HI: value_acc = {w.rx_byte, 8'h00};
                    mrr_pkg::PH_VAL_LO: value_acc[7:0] = w.rx_byte;
                    mrr_pkg::PH_CRC_LO: crc_lo_seen = w.rx_byte;
                    default:
                    begin
                        done = 1'b1;
                        if (crc_lo_seen == crc_run[7:0] && w.rx_byte == crc_run[15:8])
                        begin
                            r.status  = mrr_pkg::ST_OK;
                            r.reading = value_acc;
                        end
                        else
                        begin
                            r.status = mrr_pkg::ST_BAD_CRC;
                        end
                    end
                endcase
                if (!done)
                begin
                    if (rx_phase != mrr_pkg::PH_CRC_LO)
                        crc_run = crc_byte(crc_run, w.rx_byte);
                    if (rx_phase < mrr_pkg::PH_VAL_HI)
                        tick_run = '0;
                    rx_phase = mrr_pkg::phase_t'(rx_phase + 3'd1);
                end
            end
        end
        if (done)
        begin
            rx_armed = 1'b0;
            pending_results.push_back(r);
        end
    endtask

    task automatic send_word(input logic [1:0] mode, input logic [mrr_pkg::BYTE_W-1:0] data);
        mrr_pkg::in_word_t w;
        w.mode    = mode;
        w.rx_byte = data;
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        sent_words++;
        predict_word(w);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_word(mrr_pkg::MODE_TICK, 8'($urandom));
    endtask

    task automatic send_frame(input logic [mrr_pkg::BYTE_W-1:0] addr,
                              input logic [mrr_pkg::BYTE_W-1:0] func,
                              input logic [mrr_pkg::BYTE_W-1:0] cnt,
                              input logic [mrr_pkg::VALUE_W-1:0] val,
                              input logic [mrr_pkg::VALUE_W-1:0] crc_flip,
                              input int unsigned tick_pct, input int unsigned tick_max);
        logic [mrr_pkg::BYTE_W-1:0]  frame [7];
        logic [mrr_pkg::VALUE_W-1:0] crc;
        frame = '{addr, func, cnt, val[15:8], val[7:0], 8'h00, 8'h00};
        crc = mrr_pkg::CRC_INIT;
        for (int i = 0; i < 5; i++)
        begin
            crc = crc_byte(crc, frame[i]);
        end
        crc      = crc ^ crc_flip;
        frame[5] = crc[7:0];
        frame[6] = crc[15:8];
        send_word(mrr_pkg::MODE_START, 8'($urandom));
        for (int i = 0; i < 7; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send_ticks($urandom_range(1, tick_max));
            send_word(mrr_pkg::MODE_BYTE, frame[i]);
        end
    endtask

    // push the receiver out of a reply in progress so config can change
    task automatic close_reply();
        logic [mrr_pkg::BYTE_W-1:0] b;
        while (rx_armed)
        begin
            case (rx_phase)
                mrr_pkg::PH_ADDR:  b = cfg_shadow.slave_address ^ 8'h01;
                mrr_pkg::PH_FUNC:  b = cfg_shadow.function_code ^ 8'h01;
                mrr_pkg::PH_COUNT: b = mrr_pkg::EXPECT_COUNT ^ 8'h01;
                default:           b = 8'($urandom);
            endcase
            send_word(mrr_pkg::MODE_BYTE, b);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mrr_pkg::CFG_AW-1:0] idx,
                             input logic [mrr_pkg::CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            mrr_pkg::REG_SLAVE_ADDRESS: cfg_shadow.slave_address = val[7:0];
            mrr_pkg::REG_FUNCTION_CODE: cfg_shadow.function_code = val[7:0];
            mrr_pkg::REG_TIMEOUT_TICKS: cfg_shadow.timeout_ticks = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [mrr_pkg::BYTE_W-1:0] addr,
                              input logic [mrr_pkg::BYTE_W-1:0] func,
                              input logic [mrr_pkg::TICK_W-1:0] ticks);
        close_reply();
        drain();
        write_reg(mrr_pkg::REG_SLAVE_ADDRESS, {8'($urandom), addr});
        write_reg(mrr_pkg::REG_FUNCTION_CODE, {8'($urandom), func});
        write_reg(mrr_pkg::REG_TIMEOUT_TICKS, ticks);
    endtask

    task automatic test_ignored_words();
        send_word(mrr_pkg::MODE_BYTE, mrr_pkg::RST_SLAVE_ADDRESS);
        send_word(mrr_pkg::MODE_TICK, 8'hFF);
        send_word(MODE_UNUSED, 8'hFF);
        send_word(mrr_pkg::MODE_START, 8'h00);
        send_word(MODE_UNUSED, 8'h55);
        send_word(mrr_pkg::MODE_BYTE, 8'hAA);
    endtask

    task automatic test_good_replies();
        send_frame(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE,
                   mrr_pkg::EXPECT_COUNT, 16'h0000, '0, 0, 1);
        send_frame(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE,
                   mrr_pkg::EXPECT_COUNT, 16'hFFFF, '0, 0, 1);
    endtask

    task automatic test_header_errors();
        send_frame(8'hFF, mrr_pkg::RST_FUNCTION_CODE, mrr_pkg::EXPECT_COUNT,
                   16'h1234, '0, 0, 1);
        send_frame(mrr_pkg::RST_SLAVE_ADDRESS, 8'h00, mrr_pkg::EXPECT_COUNT,
                   16'h1234, '0, 0, 1);
        send_frame(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE, 8'h00,
                   16'h1234, '0, 0, 1);
        send_frame(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE, 8'hFF,
                   16'h1234, '0, 0, 1);
        send_frame(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE,
                   mrr_pkg::EXPECT_COUNT, 16'hA5C3, 16'h0001, 0, 1);
        send_frame(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE,
                   mrr_pkg::EXPECT_COUNT, 16'hA5C3, 16'h8000, 0, 1);
    endtask

    task automatic test_restart();
        send_word(mrr_pkg::MODE_START, 8'h00);
        send_word(mrr_pkg::MODE_BYTE, mrr_pkg::RST_SLAVE_ADDRESS);
        send_word(mrr_pkg::MODE_BYTE, mrr_pkg::RST_FUNCTION_CODE);
        send_frame(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE,
                   mrr_pkg::EXPECT_COUNT, 16'h1234, '0, 0, 1);
    endtask

    task automatic test_timeouts();
        set_config(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE, 16'd0);
        send_word(mrr_pkg::MODE_START, 8'h00);
        send_word(mrr_pkg::MODE_TICK, 8'h00);
        set_config(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE, 16'd2);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_word(mrr_pkg::MODE_START, 8'h00);
        send_ticks(3);
        // header bytes restart the timer, value bytes do not
        send_word(mrr_pkg::MODE_START, 8'h00);
        send_word(mrr_pkg::MODE_BYTE, mrr_pkg::RST_SLAVE_ADDRESS);
        send_ticks(2);
        send_word(mrr_pkg::MODE_BYTE, mrr_pkg::RST_FUNCTION_CODE);
        send_ticks(2);
        send_word(mrr_pkg::MODE_BYTE, mrr_pkg::EXPECT_COUNT);
        send_ticks(1);
        send_word(mrr_pkg::MODE_BYTE, 8'h5A);
        send_ticks(1);
        send_word(mrr_pkg::MODE_BYTE, 8'hA5);
        send_ticks(1);
    endtask

    task automatic test_random_traffic();
        int unsigned                 target;
        int unsigned                 kind;
        int unsigned                 tick_max;
        logic [mrr_pkg::VALUE_W-1:0] val;
        logic [mrr_pkg::BYTE_W-1:0]  addr;
        logic [mrr_pkg::BYTE_W-1:0]  func;
        logic [mrr_pkg::BYTE_W-1:0]  cnt;
        logic [mrr_pkg::VALUE_W-1:0] flip;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       set_config(8'h00, 8'hFF, 16'd1);
                1:       set_config(8'hFF, 8'h00, 16'hFFFF);
                2:       set_config(8'($urandom), 8'($urandom), 16'd0);
                default: set_config(8'($urandom), 8'($urandom), 16'($urandom_range(2, 12)));
            endcase
            gaps_on  = (ph % 3 != 2);
            tick_max = (cfg_shadow.timeout_ticks <= 12) ? cfg_shadow.timeout_ticks + 2 : 3;
            target   = sent_words + 115;
            while (sent_words < target)
            begin
                kind = $urandom_range(0, 99);
                case ($urandom_range(0, 3))
                    0:       val = 16'h0000;
                    1:       val = 16'hFFFF;
                    default: val = 16'($urandom);
                endcase
                addr = cfg_shadow.slave_address;
                func = cfg_shadow.function_code;
                cnt  = mrr_pkg::EXPECT_COUNT;
                flip = '0;
                if (kind < 55)
                begin
                    send_frame(addr, func, cnt, val, flip, 25, tick_max);
                end
                else if (kind < 72)
                begin
                    case ($urandom_range(0, 3))
                        0:       addr = addr ^ 8'($urandom_range(1, 255));
                        1:       func = func ^ 8'($urandom_range(1, 255));
                        2:       cnt  = cnt ^ 8'($urandom_range(1, 255));
                        default: flip = 16'($urandom_range(1, 65535));
                    endcase
                    send_frame(addr, func, cnt, val, flip, 15, tick_max);
                end
                else if (kind < 82)
                begin
                    send_word(mrr_pkg::MODE_START, 8'($urandom));
                    if (cfg_shadow.timeout_ticks <= 12)
                        send_ticks(cfg_shadow.timeout_ticks + 1);
                    else
                        send_ticks($urandom_range(1, 8));
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        send_word(2'($urandom_range(0, 3)), 8'($urandom));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // receiver held off while whole replies keep coming
    task automatic test_pressure();
        set_config(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE,
                   mrr_pkg::RST_TIMEOUT_TICKS);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (5)
            send_frame(mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE,
                       mrr_pkg::EXPECT_COUNT, 16'($urandom), '0, 0, 1);
        while (hold_req) @(posedge clk);
        drain();
        gaps_on = 1'b1;
    endtask

    initial
    begin : rx_stall
        int unsigned seg_left;
        int unsigned ready_pct;
        int unsigned hold_cnt;
        seg_left = 0;
        hold_cnt = 0;
        ready_pct = 100;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt == HOLD_CYCLES)
                begin
                    hold_req = 1'b0;
                    hold_cnt = 0;
                end
            end
            else
            begin
                if (seg_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 75;
                        2:       ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                out_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    initial
    begin : result_check
        mrr_pkg::out_word_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected word, status %0d reading %h",
                             $time, out_data.status, out_data.reading);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, out_data.status);
                        errors++;
                    end
                    if (out_data.reading !== want.reading)
                    begin
                        $display("%0t: reading mismatch, expected %h actual %h",
                                 $time, want.reading, out_data.reading);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : main_seq
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        out_ready   <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_addr    <= '0;
        cfg_wdata   <= '0;
        errors      = 0;
        sent_words  = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        hold_req    = 1'b0;
        cfg_shadow  = '{mrr_pkg::RST_SLAVE_ADDRESS, mrr_pkg::RST_FUNCTION_CODE,
                        mrr_pkg::RST_TIMEOUT_TICKS};
        rx_armed    = 1'b0;
        rx_phase    = mrr_pkg::PH_ADDR;
        crc_run     = mrr_pkg::CRC_INIT;
        value_acc   = '0;
        crc_lo_seen = '0;
        tick_run    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ignored_words();
        test_good_replies();
        test_header_errors();
        test_restart();
        test_timeouts();
        test_random_traffic();
        test_pressure();
        close_reply();
        drain();
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
